// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define PIDC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pid controller check failed");

// Clocked assertion that also holds during reset.
`define PIDC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("pid controller check failed during reset");

`endif

// ===== src/pidc_pkg.sv =====
// Shared types, constants and the clamp function of the PID controller.
`default_nettype none

package pidc_pkg;

  // Field and arithmetic widths
  localparam int GAIN_W        = 31;
  localparam int DATA_W        = 32;
  localparam int DIFF_W        = DATA_W + 1;
  localparam int PROD_W        = 64;
  localparam int ACC_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;

  // Register reset values
  localparam logic [GAIN_W-1:0]        PROP_GAIN_RST  = 31'd1310720;
  localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST = 31'd327680;
  localparam logic [GAIN_W-1:0]        DERIV_GAIN_RST = 31'd6554;
  localparam logic signed [DATA_W-1:0] OUT_MIN_RST    = -32'sd5555;
  localparam logic signed [DATA_W-1:0] OUT_MAX_RST    = 32'sd5555;
  localparam logic signed [DATA_W-1:0] TARGET_RST     = 32'sd0;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_OUT_MIN     = 3'd3,
    REG_OUT_MAX     = 3'd4,
    REG_TARGET      = 3'd5,
    REG_REVERSE_DIR = 3'd6,
    REG_AUTO_MODE   = 3'd7
  } reg_idx_t;

  // Live configuration, plus a strobe in the cycle after a limit write
  typedef struct packed {
    logic [GAIN_W-1:0]        prop_gain;
    logic [GAIN_W-1:0]        integ_gain;
    logic [GAIN_W-1:0]        deriv_gain;
    logic signed [DATA_W-1:0] out_min;
    logic signed [DATA_W-1:0] out_max;
    logic signed [DATA_W-1:0] target;
    logic                     reverse_dir;
    logic                     auto_mode;
    logic                     lim_wr;
  } cfg_t;

  // Per-sample control flags carried down the pipeline
  typedef struct packed {
    logic res;   // automatic sample, gives a result
    logic load;  // first automatic sample after manual or reset
  } flags_t;

  // Upper limit tested first: with crossed limits, a value above out_max gives out_max, any other out_min
  function automatic logic signed [DATA_W-1:0] clamp(
    input logic signed [ACC_W-1:0]  v,
    input logic signed [DATA_W-1:0] lo,
    input logic signed [DATA_W-1:0] hi
  );
    logic signed [DATA_W-1:0] r;
    priority if (v > ACC_W'(hi)) begin
      r = hi;
    end else if (v < ACC_W'(lo)) begin
      r = lo;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/pidc_cfg.sv =====
// Configuration register file of the PID controller.
`default_nettype none

module pidc_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pidc_pkg::DATA_W-1:0]      cfg_data,
  output pidc_pkg::cfg_t                        cfg
);

  pidc_pkg::cfg_t cfg_q;
  logic           wr;

  // Writes must arrive only while idle, which the block does not enforce; every beat is taken
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign cfg       = cfg_q;

  // Register writes; limit writes raise a strobe that re-clamps the state
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.prop_gain   <= pidc_pkg::PROP_GAIN_RST;
      cfg_q.integ_gain  <= pidc_pkg::INTEG_GAIN_RST;
      cfg_q.deriv_gain  <= pidc_pkg::DERIV_GAIN_RST;
      cfg_q.out_min     <= pidc_pkg::OUT_MIN_RST;
      cfg_q.out_max     <= pidc_pkg::OUT_MAX_RST;
      cfg_q.target      <= pidc_pkg::TARGET_RST;
      cfg_q.reverse_dir <= 1'b0;
      cfg_q.auto_mode   <= 1'b1;
      cfg_q.lim_wr      <= 1'b0;
    end else begin
      cfg_q.lim_wr <= 1'b0;
      if (wr) begin
        unique case (pidc_pkg::reg_idx_t'(cfg_index))
          pidc_pkg::REG_PROP_GAIN:   cfg_q.prop_gain  <= cfg_data[pidc_pkg::GAIN_W-1:0];
          pidc_pkg::REG_INTEG_GAIN:  cfg_q.integ_gain <= cfg_data[pidc_pkg::GAIN_W-1:0];
          pidc_pkg::REG_DERIV_GAIN:  cfg_q.deriv_gain <= cfg_data[pidc_pkg::GAIN_W-1:0];
          pidc_pkg::REG_OUT_MIN: begin
            cfg_q.out_min <= cfg_data;
            cfg_q.lim_wr  <= 1'b1;
          end
          pidc_pkg::REG_OUT_MAX: begin
            cfg_q.out_max <= cfg_data;
            cfg_q.lim_wr  <= 1'b1;
          end
          pidc_pkg::REG_TARGET:      cfg_q.target      <= cfg_data;
          pidc_pkg::REG_REVERSE_DIR: cfg_q.reverse_dir <= cfg_data[0];
          pidc_pkg::REG_AUTO_MODE:   cfg_q.auto_mode   <= cfg_data[0];
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/pidc_front.sv =====
// Input stage: error and measurement change, bumpless-transfer tracking.
`default_nettype none

module pidc_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire pidc_pkg::cfg_t                       cfg,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [pidc_pkg::DATA_W-1:0]   measurement,
  input  wire logic                                 dn_ready,
  output logic                                      s1_valid,
  output pidc_pkg::flags_t                          s1_flags,
  output logic signed [pidc_pkg::DIFF_W-1:0]        s1_err,
  output logic signed [pidc_pkg::DIFF_W-1:0]        s1_dmeas
);

  logic                               was_auto;
  logic signed [pidc_pkg::DATA_W-1:0] prev_meas;
  logic                               load_c;
  logic signed [pidc_pkg::DATA_W-1:0] prev_sel;
  pidc_pkg::flags_t                   flags_next;
  logic signed [pidc_pkg::DIFF_W-1:0] err_next;
  logic signed [pidc_pkg::DIFF_W-1:0] dmeas_next;
  logic                               accept;

  assign in_ready = !s1_valid || dn_ready;
  assign accept   = in_valid && in_ready;

  // Error to setpoint and change in measurement, both exact in 33 bits
  always_comb begin
    load_c          = cfg.auto_mode && !was_auto;
    prev_sel        = load_c ? measurement : prev_meas;
    flags_next.res  = cfg.auto_mode;
    flags_next.load = load_c;
    err_next        = pidc_pkg::DIFF_W'(cfg.target) - pidc_pkg::DIFF_W'(measurement);
    dmeas_next      = pidc_pkg::DIFF_W'(measurement) - pidc_pkg::DIFF_W'(prev_sel);
  end

  // Control and mode history
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      was_auto  <= 1'b0;
      prev_meas <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (accept) begin
        if (cfg.auto_mode) begin
          was_auto  <= 1'b1;
          prev_meas <= measurement;
        end else begin
          was_auto <= 1'b0;
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags <= flags_next;
      s1_err   <= err_next;
      s1_dmeas <= dmeas_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/pidc_mult.sv =====
// Multiplier stage: the three gain products, scaled down with floor rounding.
`default_nettype none

module pidc_mult #(
  parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF,
  localparam int TERM_W   = pidc_pkg::PROD_W - FRAC_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pidc_pkg::cfg_t                     cfg,
  input  wire logic                               s1_valid,
  input  wire pidc_pkg::flags_t                   s1_flags,
  input  wire logic signed [pidc_pkg::DIFF_W-1:0] s1_err,
  input  wire logic signed [pidc_pkg::DIFF_W-1:0] s1_dmeas,
  output logic                                    up_ready,
  input  wire logic                               dn_ready,
  output logic                                    s2_valid,
  output pidc_pkg::flags_t                        s2_flags,
  output logic signed [TERM_W-1:0]                s2_p,
  output logic signed [TERM_W-1:0]                s2_i,
  output logic signed [TERM_W-1:0]                s2_d
);

  logic signed [pidc_pkg::PROD_W-1:0] p_prod;
  logic signed [pidc_pkg::PROD_W-1:0] i_prod;
  logic signed [pidc_pkg::PROD_W-1:0] d_prod;
  logic                               take;

  assign up_ready = !s2_valid || dn_ready;
  assign take     = s1_valid && up_ready;

  // Unsigned 31-bit gain times signed 33-bit value, exact in 64 bits
  always_comb begin
    p_prod = pidc_pkg::PROD_W'($signed({1'b0, cfg.prop_gain}))
           * pidc_pkg::PROD_W'(s1_err);
    i_prod = pidc_pkg::PROD_W'($signed({1'b0, cfg.integ_gain}))
           * pidc_pkg::PROD_W'(s1_err);
    d_prod = pidc_pkg::PROD_W'($signed({1'b0, cfg.deriv_gain}))
           * pidc_pkg::PROD_W'(s1_dmeas);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (up_ready) begin
      s2_valid <= s1_valid;
    end
  end

  // Dropping the fraction bits of a two's complement value rounds to minus infinity
  always_ff @(posedge clk) begin
    if (take) begin
      s2_flags <= s1_flags;
      s2_p     <= p_prod[pidc_pkg::PROD_W-1:FRAC_BITS];
      s2_i     <= i_prod[pidc_pkg::PROD_W-1:FRAC_BITS];
      s2_d     <= d_prod[pidc_pkg::PROD_W-1:FRAC_BITS];
    end
  end

endmodule

`default_nettype wire

// ===== src/pidc_integ.sv =====
// Integrator stage: anti-windup integral and the combined P and D terms.
`default_nettype none

module pidc_integ #(
  parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF,
  localparam int TERM_W   = pidc_pkg::PROD_W - FRAC_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pidc_pkg::cfg_t                     cfg,
  input  wire logic signed [pidc_pkg::DATA_W-1:0] last_drive,
  input  wire logic                               s2_valid,
  input  wire pidc_pkg::flags_t                   s2_flags,
  input  wire logic signed [TERM_W-1:0]           s2_p,
  input  wire logic signed [TERM_W-1:0]           s2_i,
  input  wire logic signed [TERM_W-1:0]           s2_d,
  output logic                                    up_ready,
  input  wire logic                               dn_ready,
  output logic                                    s3_valid,
  output pidc_pkg::flags_t                        s3_flags,
  output logic signed [pidc_pkg::ACC_W-1:0]       s3_pd,
  output logic signed [pidc_pkg::DATA_W-1:0]      s3_integ
);

  logic signed [pidc_pkg::DATA_W-1:0] integral;
  logic signed [pidc_pkg::DATA_W-1:0] base;
  logic signed [pidc_pkg::ACC_W-1:0]  sum;
  logic signed [pidc_pkg::DATA_W-1:0] integ_next;
  logic signed [pidc_pkg::ACC_W-1:0]  pd_next;
  logic                               take;

  assign up_ready = !s3_valid || dn_ready;
  assign take     = s2_valid && up_ready;

  // Integral update; bumpless transfer starts from the clamped last drive
  always_comb begin
    base = s2_flags.load
         ? pidc_pkg::clamp(pidc_pkg::ACC_W'(last_drive), cfg.out_min, cfg.out_max)
         : integral;
    if (cfg.reverse_dir) begin
      sum     = pidc_pkg::ACC_W'(base) - pidc_pkg::ACC_W'(s2_i);
      pd_next = pidc_pkg::ACC_W'(s2_d) - pidc_pkg::ACC_W'(s2_p);
    end else begin
      sum     = pidc_pkg::ACC_W'(base) + pidc_pkg::ACC_W'(s2_i);
      pd_next = pidc_pkg::ACC_W'(s2_p) - pidc_pkg::ACC_W'(s2_d);
    end
    integ_next = pidc_pkg::clamp(sum, cfg.out_min, cfg.out_max);
  end

  // Integral state; manual beats pass through without touching it
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      integral <= '0;
    end else begin
      if (up_ready) begin
        s3_valid <= s2_valid;
      end
      priority if (cfg.lim_wr) begin
        integral <= pidc_pkg::clamp(pidc_pkg::ACC_W'(integral), cfg.out_min, cfg.out_max);
      end else if (take && s2_flags.res) begin
        integral <= integ_next;
      end else begin
        integral <= integral;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (take) begin
      s3_flags <= s2_flags;
      s3_pd    <= pd_next;
      s3_integ <= integ_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/pidc_out.sv =====
// Output stage: drive sum, output clamp and the result register.
`default_nettype none

module pidc_out (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pidc_pkg::cfg_t                     cfg,
  input  wire logic                               s3_valid,
  input  wire pidc_pkg::flags_t                   s3_flags,
  input  wire logic signed [pidc_pkg::ACC_W-1:0]  s3_pd,
  input  wire logic signed [pidc_pkg::DATA_W-1:0] s3_integ,
  output logic                                    up_ready,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [pidc_pkg::DATA_W-1:0]      drive,
  output logic                                    clamped_high,
  output logic                                    clamped_low,
  output logic signed [pidc_pkg::DATA_W-1:0]      last_drive
);

  logic signed [pidc_pkg::ACC_W-1:0]  raw;
  logic                               hi;
  logic                               lo;
  logic signed [pidc_pkg::DATA_W-1:0] drv;
  logic                               take;

  // Manual beats are dropped here and never wait on the result register
  assign up_ready = !s3_flags.res || !out_valid || out_ready;
  assign take     = s3_valid && up_ready && s3_flags.res;

  // Raw drive and clamp flags, upper limit first
  always_comb begin
    raw = s3_pd + pidc_pkg::ACC_W'(s3_integ);
    hi  = raw > pidc_pkg::ACC_W'(cfg.out_max);
    lo  = !hi && (raw < pidc_pkg::ACC_W'(cfg.out_min));
    drv = pidc_pkg::clamp(raw, cfg.out_min, cfg.out_max);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      last_drive <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      priority if (cfg.lim_wr) begin
        last_drive <= pidc_pkg::clamp(pidc_pkg::ACC_W'(last_drive), cfg.out_min,
                                      cfg.out_max);
      end else if (take) begin
        last_drive <= drv;
      end else begin
        last_drive <= last_drive;
      end
    end
  end

  // Result beat payload
  always_ff @(posedge clk) begin
    if (take) begin
      drive        <= drv;
      clamped_high <= hi;
      clamped_low  <= lo;
    end
  end

endmodule

`default_nettype wire

// ===== src/pid_controller_clamped.sv =====
// Clamped PID controller, derivative on measurement: four-stage pipeline.
//
// Each measurement beat passes through four register stages: input (error to
// setpoint and change in measurement), multiply (three 31x33-bit gain
// products, floor-scaled by FRAC_BITS), integrate (anti-windup integral and
// P-D combination) and output (drive sum and clamp). A beat is taken every
// cycle unless out_ready low holds the result register and the stages back up.
// The integral feedback path closes within the integrate stage; last drive is
// fed back from the output stage for bumpless transfer. In manual mode a beat
// is taken but gives no result. Writing out_min or out_max re-clamps the
// integral and last drive on the following cycle. Configuration must be
// written only while the controller is idle; the block does not enforce this.
`default_nettype none

module pid_controller_clamped #(
  parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [pidc_pkg::DATA_W-1:0] measurement,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [pidc_pkg::DATA_W-1:0]      drive,
  output logic                                    clamped_high,
  output logic                                    clamped_low,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pidc_pkg::DATA_W-1:0]        cfg_data
);

  localparam int TERM_W = pidc_pkg::PROD_W - FRAC_BITS;

  pidc_pkg::cfg_t                     cfg;
  logic                               s1_valid;
  pidc_pkg::flags_t                   s1_flags;
  logic signed [pidc_pkg::DIFF_W-1:0] s1_err;
  logic signed [pidc_pkg::DIFF_W-1:0] s1_dmeas;
  logic                               s1_ready;
  logic                               s2_valid;
  pidc_pkg::flags_t                   s2_flags;
  logic signed [TERM_W-1:0]           s2_p;
  logic signed [TERM_W-1:0]           s2_i;
  logic signed [TERM_W-1:0]           s2_d;
  logic                               s2_ready;
  logic                               s3_valid;
  pidc_pkg::flags_t                   s3_flags;
  logic signed [pidc_pkg::ACC_W-1:0]  s3_pd;
  logic signed [pidc_pkg::DATA_W-1:0] s3_integ;
  logic                               s3_ready;
  logic signed [pidc_pkg::DATA_W-1:0] last_drive;

  // Configuration registers
  pidc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input stage
  pidc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .measurement (measurement),
    .dn_ready    (s1_ready),
    .s1_valid    (s1_valid),
    .s1_flags    (s1_flags),
    .s1_err      (s1_err),
    .s1_dmeas    (s1_dmeas)
  );

  // Multiply stage
  pidc_mult #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mult (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_flags (s1_flags),
    .s1_err   (s1_err),
    .s1_dmeas (s1_dmeas),
    .up_ready (s1_ready),
    .dn_ready (s2_ready),
    .s2_valid (s2_valid),
    .s2_flags (s2_flags),
    .s2_p     (s2_p),
    .s2_i     (s2_i),
    .s2_d     (s2_d)
  );

  // Integrate stage
  pidc_integ #(
    .FRAC_BITS (FRAC_BITS)
  ) u_integ (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .last_drive (last_drive),
    .s2_valid   (s2_valid),
    .s2_flags   (s2_flags),
    .s2_p       (s2_p),
    .s2_i       (s2_i),
    .s2_d       (s2_d),
    .up_ready   (s2_ready),
    .dn_ready   (s3_ready),
    .s3_valid   (s3_valid),
    .s3_flags   (s3_flags),
    .s3_pd      (s3_pd),
    .s3_integ   (s3_integ)
  );

  // Output stage
  pidc_out u_out (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .s3_valid     (s3_valid),
    .s3_flags     (s3_flags),
    .s3_pd        (s3_pd),
    .s3_integ     (s3_integ),
    .up_ready     (s3_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive        (drive),
    .clamped_high (clamped_high),
    .clamped_low  (clamped_low),
    .last_drive   (last_drive)
  );

endmodule

`default_nettype wire

// ===== src/pidc_checker.sv =====
// Port-level checks on the PID controller, bound to its top level.
`default_nettype none

`include "assert_macros.svh"

module pidc_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [pidc_pkg::DATA_W-1:0] drive,
  input wire logic                               clamped_high,
  input wire logic                               clamped_low
);

  // A drive is limited at one side only
  `PIDC_ASSERT(a_clamp_excl, clk, rst, out_valid |-> !(clamped_high && clamped_low))

  // Reset empties the result register
  `PIDC_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid)

  // A held result beat keeps its payload
  `PIDC_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(clamped_high) && $stable(clamped_low))

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .drive        (drive),
  .clamped_high (clamped_high),
  .clamped_low  (clamped_low)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the clamped PID controller: directed table, then random phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pidc_pkg::*;

  localparam int FRAC           = FRAC_BITS_DEF;
  localparam int SETTLE         = 8;    // four pipeline stages plus margin
  localparam int HOLD_CYCLES    = 64;   // long receiver hold-off
  localparam int RANDOM_SAMPLES = 1200;
  localparam int PRINT_CAP      = 100;

  typedef struct packed {
    logic signed [DATA_W-1:0] drv;
    logic                     hi;
    logic                     lo;
  } drive_res_t;

  typedef struct {
    bit              is_wr;
    reg_idx_t        idx;
    logic [DATA_W-1:0] val;
    bit              typed;
    drive_res_t      res;
  } stim_row_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

  // DUT connections, all inputs known from time zero
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] measurement = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b1;
  logic signed [DATA_W-1:0] drive;
  logic                     clamped_high;
  logic                     clamped_low;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  reg_idx_t                 cfg_index = REG_PROP_GAIN;
  logic [DATA_W-1:0]        cfg_data = '0;

  // Controller model: configuration copy
  longint g_prop, g_integ, g_deriv, lim_lo, lim_hi, setpoint;
  bit     rev, auto_on;
  // Controller model: loop state
  longint integ_acc, prev_meas, last_drv;
  bit     was_auto;

  drive_res_t pending_drives[$];
  stim_row_t  plan[$];
  int         mismatches = 0;
  int         auto_count = 0;
  int         burst_left = 0;
  bit         gapless = 1'b0;
  bit         cfg_open = 1'b0;
  bit         hold_req = 1'b0;

  pid_controller_clamped dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .measurement  (measurement),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive        (drive),
    .clamped_high (clamped_high),
    .clamped_low  (clamped_low),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic note_mismatch(input string what);
    // print is capped so a broken build does not flood the log
    if (mismatches < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic void model_reset();
    g_prop    = longint'(PROP_GAIN_RST);
    g_integ   = longint'(INTEG_GAIN_RST);
    g_deriv   = longint'(DERIV_GAIN_RST);
    lim_lo    = longint'(OUT_MIN_RST);
    lim_hi    = longint'(OUT_MAX_RST);
    setpoint  = longint'(TARGET_RST);
    rev       = 1'b0;
    auto_on   = 1'b1;
    integ_acc = 0;
    prev_meas = 0;
    last_drv  = 0;
    was_auto  = 1'b0;
  endfunction

  // Upper limit tested first: with crossed limits, a value above it gives the upper limit, any other the lower
  function automatic longint limit(input longint v);
    if (v > lim_hi) return lim_hi;
    if (v < lim_lo) return lim_lo;
    return v;
  endfunction

  // Gain in Q.FRAC times an integer, floored, negated when reverse acting
  function automatic longint gain_term(input longint g, input longint x);
    longint t;
    t = (g * x) >>> FRAC;
    return rev ? -t : t;
  endfunction

  function automatic void model_write(input reg_idx_t idx, input logic [DATA_W-1:0] v);
    case (idx)
      REG_PROP_GAIN:   g_prop  = longint'(v[GAIN_W-1:0]);
      REG_INTEG_GAIN:  g_integ = longint'(v[GAIN_W-1:0]);
      REG_DERIV_GAIN:  g_deriv = longint'(v[GAIN_W-1:0]);
      REG_OUT_MIN, REG_OUT_MAX: begin
        if (idx == REG_OUT_MIN) lim_lo = longint'($signed(v));
        else lim_hi = longint'($signed(v));
        // new limits pull the stored integral and drive inside them
        integ_acc = limit(integ_acc);
        last_drv  = limit(last_drv);
      end
      REG_TARGET:      setpoint = longint'($signed(v));
      REG_REVERSE_DIR: rev = v[0];
      REG_AUTO_MODE:   auto_on = v[0];
      default: ;
    endcase
  endfunction

  // One sample through the controller; returns 1 when a drive beat is due
  function automatic bit compute_drive(input logic signed [DATA_W-1:0] m,
                                       output drive_res_t r);
    longint meas, err, raw;
    meas = longint'(m);
    r = '0;
    if (!auto_on) begin
      was_auto = 1'b0;
      return 1'b0;
    end
    // bumpless transfer on entry to automatic
    if (!was_auto) begin
      integ_acc = limit(last_drv);
      prev_meas = meas;
      was_auto  = 1'b1;
    end
    err       = setpoint - meas;
    integ_acc = limit(integ_acc + gain_term(g_integ, err));
    raw = gain_term(g_prop, err) + integ_acc - gain_term(g_deriv, meas - prev_meas);
    if (raw > lim_hi) begin
      r.drv = lim_hi[DATA_W-1:0];
      r.hi  = 1'b1;
    end else if (raw < lim_lo) begin
      r.drv = lim_lo[DATA_W-1:0];
      r.lo  = 1'b1;
    end else begin
      r.drv = raw[DATA_W-1:0];
    end
    prev_meas = meas;
    last_drv  = longint'(r.drv);
    return 1'b1;
  endfunction

  // Directed table rows
  function automatic void add_wr(input reg_idx_t idx, input logic [DATA_W-1:0] v);
    stim_row_t row;
    row = '{is_wr: 1'b1, idx: idx, val: v, typed: 1'b0, res: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_sample(input logic signed [DATA_W-1:0] m);
    stim_row_t row;
    row = '{is_wr: 1'b0, idx: REG_PROP_GAIN, val: m, typed: 1'b0, res: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_checked(input logic signed [DATA_W-1:0] m,
                                      input logic signed [DATA_W-1:0] d,
                                      input logic hi, input logic lo);
    stim_row_t row;
    row = '{is_wr: 1'b0, idx: REG_PROP_GAIN, val: m, typed: 1'b1, res: '{d, hi, lo}};
    plan.push_back(row);
  endfunction

  // Stop offering samples, let every drive beat out, then let the pipe empty
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes; the next sample lowers it
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] v);
    if (!cfg_open) begin
      settle_idle();
      cfg_open = 1'b1;
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    model_write(idx, v);
  endtask

  task automatic send_sample(input logic signed [DATA_W-1:0] m, input bit typed,
                             input drive_res_t want);
    drive_res_t r;
    int gap;
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
    // bursts of random length separated by random gaps
    if (!gapless) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid    <= 1'b1;
    measurement <= m;
    do @(posedge clk); while (!in_ready);
    if (compute_drive(m, r)) begin
      auto_count++;
      pending_drives.push_back(typed ? want : r);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3, 4:    return $urandom;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_meas();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7FFF_FFFF;
          2:       return '0;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return $urandom;
      // close to the setpoint, where the loop is not saturated
      default: return DATA_W'(setpoint + longint'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // Drive beat checker
  always @(posedge clk) begin : check_drive
    drive_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        note_mismatch($sformatf("drive beat %0d with nothing pending", drive));
      end else begin
        want = pending_drives.pop_front();
        if (drive !== want.drv)
          note_mismatch($sformatf("drive %0d, expected %0d", drive, want.drv));
        if (clamped_high !== want.hi)
          note_mismatch($sformatf("clamped_high %b, expected %b", clamped_high, want.hi));
        if (clamped_low !== want.lo)
          note_mismatch($sformatf("clamped_low %b, expected %b", clamped_low, want.lo));
      end
    end
  end

  // Receiver: segments of open, random and sparse ready, plus one long hold-off
  initial begin : receiver
    rx_mode_t mode;
    int seg_left;
    mode = RX_OPEN;
    seg_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          seg_left = $urandom_range(1, 40);
        end
        seg_left--;
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    stim_row_t row;
    logic [DATA_W-1:0] lo_v, hi_v;
    bit want_auto;
    int phase, n;

    model_reset();

    // From reset: zero sample, then both measurement extremes saturate the drive
    add_checked(32'sd0, 32'sd0, 1'b0, 1'b0);
    add_checked(32'sh7FFF_FFFF, -32'sd5555, 1'b0, 1'b1);
    add_checked(32'sh8000_0000, 32'sd5555, 1'b1, 1'b0);
    add_sample(32'sd0);
    add_sample(32'sd1);
    add_sample(-32'sd1);
    add_sample(32'sd100);
    add_sample(-32'sd100);
    // Largest P and D gains (top data bit must be dropped), zero I gain, full-range limits
    add_wr(REG_PROP_GAIN, 32'hFFFF_FFFF);
    add_wr(REG_INTEG_GAIN, 32'h0);
    add_wr(REG_DERIV_GAIN, 32'h7FFF_FFFF);
    add_wr(REG_OUT_MIN, 32'h8000_0000);
    add_wr(REG_OUT_MAX, 32'h7FFF_FFFF);
    add_wr(REG_TARGET, 32'h7FFF_FFFF);
    add_sample(32'sh8000_0000);   // largest positive error
    add_sample(32'sh7FFF_FFFF);
    add_sample(32'sd0);
    add_wr(REG_TARGET, 32'h8000_0000);
    add_sample(32'sh7FFF_FFFF);   // largest negative error
    add_sample(32'sh8000_0000);
    // Reverse acting
    add_wr(REG_REVERSE_DIR, 32'h1);
    add_sample(32'sd1000);
    add_sample(-32'sd1000);
    // Crossed limits with moderate gains
    add_wr(REG_PROP_GAIN, 32'h0001_0000);
    add_wr(REG_INTEG_GAIN, 32'h0000_8000);
    add_wr(REG_DERIV_GAIN, 32'h0001_0000);
    add_wr(REG_TARGET, 32'h0);
    add_wr(REG_OUT_MAX, -32'sd100);
    add_wr(REG_OUT_MIN, 32'sd100);
    add_sample(32'sd0);
    add_sample(32'sd5);
    // Manual gives no drive, then bumpless return to automatic
    add_wr(REG_REVERSE_DIR, 32'h0);
    add_wr(REG_OUT_MIN, -32'sd1000);
    add_wr(REG_OUT_MAX, 32'sd1000);
    add_wr(REG_AUTO_MODE, 32'h0);
    add_sample(32'sd50);
    add_sample(32'sd60);
    add_wr(REG_AUTO_MODE, 32'h1);
    add_sample(32'sd70);
    add_sample(32'sd80);
    // Equal limits
    add_wr(REG_OUT_MIN, 32'sd7);
    add_wr(REG_OUT_MAX, 32'sd7);
    add_sample(32'sd3);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_wr) write_reg(row.idx, row.val);
      else send_sample($signed(row.val), row.typed, row.res);
    end

    // Random phases: new settings while idle, then a run of samples
    auto_count = 0;
    phase = 0;
    while (auto_count < RANDOM_SAMPLES) begin
      settle_idle();
      cfg_open = 1'b1;
      if ($urandom_range(0, 2) == 0) write_reg(REG_PROP_GAIN, pick_gain());
      if ($urandom_range(0, 2) == 0) write_reg(REG_INTEG_GAIN, pick_gain());
      if ($urandom_range(0, 2) == 0) write_reg(REG_DERIV_GAIN, pick_gain());
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 9))
          0: begin
            lo_v = 32'h8000_0000;
            hi_v = 32'h7FFF_FFFF;
          end
          1: begin
            lo_v = $urandom_range(0, 5000);
            hi_v = -$urandom_range(0, 5000);
          end
          2: begin
            lo_v = $urandom;
            hi_v = $urandom;
          end
          default: begin
            lo_v = -$urandom_range(0, 1 << 20);
            hi_v = $urandom_range(0, 1 << 20);
          end
        endcase
        if ($urandom_range(0, 1) == 0) begin
          write_reg(REG_OUT_MIN, lo_v);
          write_reg(REG_OUT_MAX, hi_v);
        end else begin
          write_reg(REG_OUT_MAX, hi_v);
          write_reg(REG_OUT_MIN, lo_v);
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0:       write_reg(REG_TARGET, 32'h8000_0000);
          1:       write_reg(REG_TARGET, 32'h7FFF_FFFF);
          2:       write_reg(REG_TARGET, $urandom);
          default: write_reg(REG_TARGET, DATA_W'(longint'($urandom_range(0, 1 << 17)) - 65536));
        endcase
      end
      // upper data bits are noise for the one-bit registers
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_REVERSE_DIR, (32'($urandom) & ~32'd1) | 32'($urandom_range(0, 1)));
      want_auto = ($urandom_range(0, 9) != 0) || (phase == 3);
      if (want_auto != auto_on || $urandom_range(0, 3) == 0)
        write_reg(REG_AUTO_MODE, (32'($urandom) & ~32'd1) | 32'(want_auto));

      gapless = (phase % 4 == 1);
      n = auto_on ? $urandom_range(10, 60) : $urandom_range(2, 8);
      // receiver holds off while samples keep coming, so the pipe backs up
      if (phase == 3) begin
        hold_req = 1'b1;
        gapless = 1'b1;
        n = 40;
      end
      repeat (n) send_sample(pick_meas(), 1'b0, '0);
      phase++;
    end

    settle_idle();
    if (mismatches == 0 && pending_drives.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/pidc_pkg.sv
src/pidc_cfg.sv
src/pidc_front.sv
src/pidc_mult.sv
src/pidc_integ.sv
src/pidc_out.sv
src/pid_controller_clamped.sv
src/pidc_checker.sv
tb/tb.sv
